// ===== src/box_blur_edge_clamped_top_macros.svh =====
// Assertion macros used by the box blur top level.
`ifndef BOX_BLUR_EDGE_CLAMPED_TOP_MACROS_SVH
`define BOX_BLUR_EDGE_CLAMPED_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bbe_pkg.sv =====
// Package with constants and types of the box blur block.
`timescale 1ns / 1ps
package bbe_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 20;
  localparam int NUM_CH         = 4;

  localparam logic [4:0]  RADIUS_RST = 5'd8;
  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [10:0] HEIGHT_RST = 11'd1024;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WIN,
    ST_LAST,
    ST_DSTART,
    ST_DIV,
    ST_HOLD
  } state_e;

endpackage

// ===== src/box_blur_edge_clamped_top.sv =====
// Top level of the streaming RGBA box blur with replicated image borders.
// An item inside the startup lag yields no result and leaves the block idle; otherwise a result
// is registered after the one-read-per-cycle window walk over the row store and the
// bit-serial divider (SUM_W is 19 at default sizes).
// One item at a time: the next request is taken only after the result is
// registered. Reset clears control state and returns the configuration to its defaults.
`timescale 1ns / 1ps
`include "box_blur_edge_clamped_top_macros.svh"
module box_blur_edge_clamped_top #(
  parameter int MAX_WIDTH  = bbe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbe_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bbe_pkg::MAX_RADIUS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic [9:0]  out_x_o,
  output logic [9:0]  out_y_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WDW        = $clog2(MAX_WIDTH + 1);
  localparam int HDW        = $clog2(MAX_HEIGHT + 1);
  localparam int RW         = $clog2(MAX_RADIUS + 1);
  localparam int SW         = $clog2(STORE_ROWS);
  localparam int DCW        = $clog2(2 * MAX_RADIUS + 1);
  localparam int LAG_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int NW         = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W      = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int CW0        = (XW > YW) ? XW : YW;
  localparam int CW1        = (CW0 > RW + 1) ? CW0 : RW + 1;
  localparam int CW         = CW1 + 2;

  bbe_pkg::state_e state_q, state_d;

  logic [4:0]  cfg_radius_q;
  logic [10:0] cfg_width_q;
  logic [10:0] cfg_height_q;

  logic             frame_active_q;
  logic [RW-1:0]    act_r_q;
  logic [WDW-1:0]   act_w_q;
  logic [HDW-1:0]   act_h_q;
  logic [NW-1:0]    n_q;
  logic [LAG_W-1:0] lag_q;
  logic [XW-1:0]    in_col_q;
  logic [HDW-1:0]   in_row_q;
  logic [SW-1:0]    in_slot_q;
  logic [XW-1:0]    out_col_q;
  logic [YW-1:0]    out_row_q;
  logic [SW-1:0]    out_slot_q;

  logic [XW-1:0]  cx_q;
  logic [YW-1:0]  cy_q;
  logic           done_q;
  logic [DCW-1:0] dx_q;
  logic [DCW-1:0] dy_q;
  logic [YW-1:0]  yy_q;
  logic [SW-1:0]  slot_q;
  logic           rd_pend_q;
  logic [bbe_pkg::NUM_CH-1:0][SUM_W-1:0] sum_q;

  logic       out_valid_q;
  logic [7:0] out_red_q, out_green_q, out_blue_q, out_alpha_q;
  logic [9:0] out_x_q, out_y_q;
  logic       frame_done_q;

  logic             accept;
  logic             new_frame;
  logic [RW-1:0]    ar_s;
  logic [WDW-1:0]   aw_s;
  logic [HDW-1:0]   ah_s;
  logic [NW-1:0]    t_s;
  logic [NW-1:0]    n_s;
  logic [LAG_W-1:0] lag_s;
  logic [HDW-1:0]   ah_e;
  logic [WDW-1:0]   aw_e;
  logic [LAG_W-1:0] lag_e;
  logic [XW-1:0]    in_col_e;
  logic [HDW-1:0]   in_row_e;
  logic [SW-1:0]    in_slot_e;
  logic             store;
  logic             proceed;

  logic signed [CW-1:0] x_raw;
  logic signed [CW-1:0] y0_raw;
  logic signed [CW-1:0] yn_raw;
  logic [XW-1:0]        xx;
  logic [YW-1:0]        yn;
  logic [XW-1:0]        aw_m1;
  logic [YW-1:0]        ah_m1;
  logic [DCW-1:0]       two_r;
  logic                 out_free;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [31:0]         mem_rdata;
  logic                div_done;
  logic [bbe_pkg::NUM_CH-1:0][7:0] quot;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != bbe_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_radius_q <= bbe_pkg::RADIUS_RST;
      cfg_width_q  <= bbe_pkg::WIDTH_RST;
      cfg_height_q <= bbe_pkg::HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bbe_pkg::cfg_idx_e'(cfg_index_i))
        bbe_pkg::CFG_RADIUS: cfg_radius_q <= cfg_data_i[4:0];
        bbe_pkg::CFG_WIDTH:  cfg_width_q  <= cfg_data_i;
        bbe_pkg::CFG_HEIGHT: cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ar_s = (32'(cfg_radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius_q);
    if (cfg_width_q == '0) begin
      aw_s = WDW'(1);
    end else if (32'(cfg_width_q) > MAX_WIDTH) begin
      aw_s = WDW'(MAX_WIDTH);
    end else begin
      aw_s = WDW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      ah_s = HDW'(1);
    end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
      ah_s = HDW'(MAX_HEIGHT);
    end else begin
      ah_s = HDW'(cfg_height_q);
    end
    t_s = NW'({ar_s, 1'b1});
    n_s = NW'(t_s * t_s);
    lag_s = LAG_W'(LAG_W'(ar_s) * LAG_W'(aw_s));
    if (32'(ar_s) < 32'(aw_s) - 32'd1) begin
      lag_s = lag_s + LAG_W'(ar_s);
    end else begin
      lag_s = lag_s + LAG_W'(aw_s - 1'b1);
    end
    new_frame = !frame_active_q;
    ah_e      = new_frame ? ah_s : act_h_q;
    aw_e      = new_frame ? aw_s : act_w_q;
    lag_e     = new_frame ? lag_s : lag_q;
    in_col_e  = new_frame ? '0 : in_col_q;
    in_row_e  = new_frame ? '0 : in_row_q;
    in_slot_e = new_frame ? '0 : in_slot_q;
    store     = in_row_e < ah_e;
    proceed   = (new_frame || store) ? !opcode_i : 1'b1;
  end

  assign mem_we    = accept && proceed && store;
  assign mem_waddr = ADDR_W'(ADDR_W'(in_slot_e) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(in_col_e);

  always_comb begin
    aw_m1  = XW'(act_w_q - 1'b1);
    ah_m1  = YW'(act_h_q - 1'b1);
    two_r  = DCW'({act_r_q, 1'b0});
    x_raw  = $signed(CW'(cx_q)) - $signed(CW'(act_r_q)) + $signed(CW'(dx_q));
    y0_raw = $signed(CW'(out_row_q)) - $signed(CW'(act_r_q));
    yn_raw = $signed(CW'(cy_q)) - $signed(CW'(act_r_q)) + $signed(CW'(dy_q))
             + $signed(CW'(1));
    if (x_raw < 0) begin
      xx = '0;
    end else if (x_raw > $signed(CW'(aw_m1))) begin
      xx = aw_m1;
    end else begin
      xx = XW'(x_raw);
    end
    if (yn_raw < 0) begin
      yn = '0;
    end else if (yn_raw > $signed(CW'(ah_m1))) begin
      yn = ah_m1;
    end else begin
      yn = YW'(yn_raw);
    end
  end

  assign mem_raddr = ADDR_W'(ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(xx);

  bbe_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i({alpha_i, blue_i, green_i, red_i}),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  bbe_div #(
    .SUM_W(SUM_W),
    .NW   (NW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == bbe_pkg::ST_DSTART),
    .dividend_i(sum_q),
    .divisor_i (n_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      bbe_pkg::ST_IDLE: begin
        if (accept && proceed && (lag_e == '0)) begin
          state_d = bbe_pkg::ST_SETUP;
        end
      end
      bbe_pkg::ST_SETUP: state_d = bbe_pkg::ST_WIN;
      bbe_pkg::ST_WIN: begin
        if ((dx_q == two_r) && (dy_q == two_r)) begin
          state_d = bbe_pkg::ST_LAST;
        end
      end
      bbe_pkg::ST_LAST:   state_d = bbe_pkg::ST_DSTART;
      bbe_pkg::ST_DSTART: state_d = bbe_pkg::ST_DIV;
      bbe_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = bbe_pkg::ST_HOLD;
        end
      end
      bbe_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = bbe_pkg::ST_IDLE;
        end
      end
      default: state_d = bbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_active_q <= 1'b0;
      act_r_q        <= '0;
      act_w_q        <= WDW'(1);
      act_h_q        <= HDW'(1);
      n_q            <= NW'(1);
      lag_q          <= '0;
      in_col_q       <= '0;
      in_row_q       <= '0;
      in_slot_q      <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_slot_q     <= '0;
      rd_pend_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == bbe_pkg::ST_WIN);
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == bbe_pkg::ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end
      if (accept && proceed) begin
        if (new_frame) begin
          frame_active_q <= 1'b1;
          act_r_q        <= ar_s;
          act_w_q        <= aw_s;
          act_h_q        <= ah_s;
          n_q            <= n_s;
          out_col_q      <= '0;
          out_row_q      <= '0;
          out_slot_q     <= '0;
        end
        in_col_q  <= in_col_e;
        in_row_q  <= in_row_e;
        in_slot_q <= in_slot_e;
        if (store) begin
          if (WDW'(in_col_e) + 1'b1 >= aw_e) begin
            in_col_q  <= '0;
            in_row_q  <= in_row_e + 1'b1;
            in_slot_q <= (in_slot_e == SW'(STORE_ROWS - 1)) ? '0 : in_slot_e + 1'b1;
          end else begin
            in_col_q <= in_col_e + 1'b1;
          end
        end
        lag_q <= (lag_e != '0) ? lag_e - 1'b1 : '0;
      end
      if (state_q == bbe_pkg::ST_SETUP) begin
        if (out_col_q == aw_m1) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + 1'b1;
          out_slot_q <= (out_slot_q == SW'(STORE_ROWS - 1)) ? '0 : out_slot_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
        if ((out_col_q == aw_m1) && (out_row_q == ah_m1)) begin
          frame_active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bbe_pkg::ST_SETUP) begin
      cx_q   <= out_col_q;
      cy_q   <= out_row_q;
      done_q <= (out_col_q == aw_m1) && (out_row_q == ah_m1);
      dx_q   <= '0;
      dy_q   <= '0;
      sum_q  <= '0;
      if (y0_raw < 0) begin
        yy_q   <= '0;
        slot_q <= '0;
      end else begin
        yy_q <= YW'(y0_raw);
        if (SW'(act_r_q) <= out_slot_q) begin
          slot_q <= out_slot_q - SW'(act_r_q);
        end else begin
          slot_q <= SW'(SW'(STORE_ROWS) + out_slot_q - SW'(act_r_q));
        end
      end
    end else begin
      if (state_q == bbe_pkg::ST_WIN) begin
        if (dx_q == two_r) begin
          dx_q <= '0;
          if (dy_q != two_r) begin
            dy_q <= dy_q + 1'b1;
            if (yn != yy_q) begin
              yy_q   <= yn;
              slot_q <= (slot_q == SW'(STORE_ROWS - 1)) ? '0 : slot_q + 1'b1;
            end
          end
        end else begin
          dx_q <= dx_q + 1'b1;
        end
      end
      if (rd_pend_q) begin
        for (int c = 0; c < bbe_pkg::NUM_CH; c++) begin
          sum_q[c] <= sum_q[c] + SUM_W'(mem_rdata[8*c +: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bbe_pkg::ST_HOLD && out_free) begin
      out_red_q    <= quot[0];
      out_green_q  <= quot[1];
      out_blue_q   <= quot[2];
      out_alpha_q  <= quot[3];
      out_x_q      <= 10'(cx_q);
      out_y_q      <= 10'(cy_q);
      frame_done_q <= done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_red_q;
  assign out_green_o  = out_green_q;
  assign out_blue_o   = out_blue_q;
  assign out_alpha_o  = out_alpha_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign frame_done_o = frame_done_q;

  `BBE_ASSERT_IMP(a_rise_from_hold, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == bbe_pkg::ST_HOLD), "Result appeared without a finished division.")
  `BBE_ASSERT_IMP(a_raddr_range, clk_i, rst_ni, state_q == bbe_pkg::ST_WIN, 32'(mem_raddr) < DEPTH, "Window read beyond the row store.")
  `BBE_ASSERT_NXT(a_div_done_state, clk_i, rst_ni, state_q == bbe_pkg::ST_DSTART, state_q == bbe_pkg::ST_DIV && !div_done, "Divider finished out of step with the sequencer.")

endmodule

// ===== src/bbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bbe_div.sv =====
// Iterative restoring divider for the four channel sums, one quotient bit per cycle.
`timescale 1ns / 1ps
module bbe_div #(
  parameter int SUM_W = 19,
  parameter int NW    = 11
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [bbe_pkg::NUM_CH-1:0][SUM_W-1:0] dividend_i,
  input  logic [NW-1:0]                         divisor_i,
  output logic                                  done_o,
  output logic [bbe_pkg::NUM_CH-1:0][7:0]       quot_o
);

  localparam int CNTW = $clog2(SUM_W + 1);

  logic                                  busy_q;
  logic                                  done_q;
  logic [CNTW-1:0]                       cnt_q;
  logic [bbe_pkg::NUM_CH-1:0][NW-1:0]    rem_q;
  logic [bbe_pkg::NUM_CH-1:0][SUM_W-1:0] quo_q;
  logic [bbe_pkg::NUM_CH-1:0][NW-1:0]    rem_d;
  logic [bbe_pkg::NUM_CH-1:0][SUM_W-1:0] quo_d;
  logic [NW:0]                           trial;

  always_comb begin
    for (int c = 0; c < bbe_pkg::NUM_CH; c++) begin
      trial = {rem_q[c], quo_q[c][SUM_W-1]};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d[c] = NW'(trial - {1'b0, divisor_i});
        quo_d[c] = {quo_q[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_d[c] = trial[NW-1:0];
        quo_d[c] = {quo_q[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    for (int c = 0; c < bbe_pkg::NUM_CH; c++) begin
      quot_o[c] = quo_q[c][7:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== verif/tb_box_blur_edge_clamped_top.sv =====
// Self-checking testbench for the edge-clamped RGBA box blur, directed plan then random frames.
`timescale 1ns / 1ps
module tb_box_blur_edge_clamped_top;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam int STORE_ROWS = 2 * bbe_pkg::MAX_RADIUS_DEF + 2;
  localparam int ITEM_TARGET = 1850;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 4000;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [9:0] x;
    logic [9:0] y;
    logic       done;
  } blur_px_t;

  typedef struct {
    bit                le_dummy_unused;
  } unused_t;

  typedef struct {
    bit                is_cfg;
    bbe_pkg::cfg_idx_e idx;
    logic [10:0]       data;
    logic              op;
    logic [31:0]       px;
    bit                typed;
    logic [31:0]       typed_px;
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic [7:0]  alpha_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic [7:0]  out_alpha_o;
  logic [9:0]  out_x_o;
  logic [9:0]  out_y_o;
  logic        frame_done_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [10:0] cfg_data_i;

  box_blur_edge_clamped_top u_dut (.*);

  // Blur predictor state.
  logic [31:0] line_mem [STORE_ROWS][bbe_pkg::MAX_WIDTH_DEF];
  int unsigned reg_radius = bbe_pkg::RADIUS_RST;
  int unsigned reg_width = bbe_pkg::WIDTH_RST;
  int unsigned reg_height = bbe_pkg::HEIGHT_RST;
  bit          frame_busy;
  int unsigned frm_r, frm_w, frm_h, lag_left;
  int unsigned wr_x, wr_y, rd_x, rd_y;
  blur_px_t    blur_q [$];

  logic        req_typed;
  logic [31:0] req_typed_px;
  bit          calm;
  int          stall_left;
  int          errors;
  int          items_sent;
  longint      cycles;

  step_t plan [25] = '{
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_DRAIN, 32'h0, 1'b0, 32'h0},
    '{1'b1, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b1, bbe_pkg::CFG_WIDTH, 11'd2, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b1, bbe_pkg::CFG_HEIGHT, 11'd2, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'h00000000, 1'b1, 32'h00000000},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'hA5A55A5A, 1'b1, 32'hA5A55A5A},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'h5A5AA5A5, 1'b1, 32'h5A5AA5A5},
    '{1'b1, bbe_pkg::CFG_RADIUS, 11'd2, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b1, bbe_pkg::CFG_WIDTH, 11'd1, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b1, bbe_pkg::CFG_HEIGHT, 11'd1, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'h12345678, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_DRAIN, 32'h0, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_DRAIN, 32'h0, 1'b1, 32'h12345678},
    '{1'b1, bbe_pkg::CFG_RADIUS, 11'd1, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b1, bbe_pkg::CFG_WIDTH, 11'd2, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b1, bbe_pkg::CFG_HEIGHT, 11'd2, OP_PIXEL, 32'h0, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'h80FF0001, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_DRAIN, 32'h0, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'h7F00FF02, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'h01808003, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'hFE7F7F04, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_PIXEL, 32'hDEADBEEF, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_DRAIN, 32'h0, 1'b0, 32'h0},
    '{1'b0, bbe_pkg::CFG_RADIUS, 11'd0, OP_DRAIN, 32'h0, 1'b0, 32'h0}
  };

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned max);
    if (v == 0) return 1;
    return (v > max) ? max : v;
  endfunction

  function automatic int clamp_pos(int v, int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  // Returns 1 and the blurred pixel when the request yields a result.
  function automatic bit blur_accept(logic op, logic [31:0] px, output blur_px_t res);
    int unsigned sum [4];
    int unsigned area;
    logic [31:0] p;
    int yy;
    res = '0;
    if (!frame_busy) begin
      if (op == OP_DRAIN) return 0;
      frm_r = (reg_radius > bbe_pkg::MAX_RADIUS_DEF) ? bbe_pkg::MAX_RADIUS_DEF : reg_radius;
      frm_w = clamp_dim(reg_width, bbe_pkg::MAX_WIDTH_DEF);
      frm_h = clamp_dim(reg_height, bbe_pkg::MAX_HEIGHT_DEF);
      lag_left = frm_r * frm_w + ((frm_r < frm_w - 1) ? frm_r : frm_w - 1);
      wr_x = 0;
      wr_y = 0;
      rd_x = 0;
      rd_y = 0;
      frame_busy = 1'b1;
    end
    if (wr_y < frm_h) begin
      if (op == OP_DRAIN) return 0;
      line_mem[wr_y % STORE_ROWS][wr_x] = px;
      wr_x++;
      if (wr_x >= frm_w) begin
        wr_x = 0;
        wr_y++;
      end
    end
    if (lag_left > 0) begin
      lag_left--;
      return 0;
    end
    for (int c = 0; c < 4; c++) sum[c] = 0;
    for (int dy = -int'(frm_r); dy <= int'(frm_r); dy++) begin
      yy = clamp_pos(int'(rd_y) + dy, int'(frm_h) - 1);
      for (int dx = -int'(frm_r); dx <= int'(frm_r); dx++) begin
        p = line_mem[yy % STORE_ROWS][clamp_pos(int'(rd_x) + dx, int'(frm_w) - 1)];
        for (int c = 0; c < 4; c++) sum[c] += p[8*c +: 8];
      end
    end
    area = (2 * frm_r + 1) * (2 * frm_r + 1);
    res.red = 8'(sum[0] / area);
    res.green = 8'(sum[1] / area);
    res.blue = 8'(sum[2] / area);
    res.alpha = 8'(sum[3] / area);
    res.x = 10'(rd_x);
    res.y = 10'(rd_y);
    res.done = (rd_x == frm_w - 1) && (rd_y == frm_h - 1);
    rd_x++;
    if (rd_x >= frm_w) begin
      rd_x = 0;
      rd_y++;
    end
    if (res.done) frame_busy = 1'b0;
    return 1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    blur_px_t res;
    blur_px_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (blur_accept(opcode_i, {alpha_i, blue_i, green_i, red_i}, res)) begin
          if (req_typed) {res.alpha, res.blue, res.green, res.red} = req_typed_px;
          blur_q.push_back(res);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (bbe_pkg::cfg_idx_e'(cfg_index_i))
          bbe_pkg::CFG_RADIUS: begin
            reg_radius = cfg_data_i[4:0];
          end
          bbe_pkg::CFG_WIDTH: begin
            reg_width = cfg_data_i;
          end
          bbe_pkg::CFG_HEIGHT: begin
            reg_height = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (blur_q.size() == 0) begin
          report_mismatch("unexpected request", 0, 1);
        end else begin
          want = blur_q.pop_front();
          if (out_red_o !== want.red) report_mismatch("out_red", out_red_o, want.red);
          if (out_green_o !== want.green) report_mismatch("out_green", out_green_o, want.green);
          if (out_blue_o !== want.blue) report_mismatch("out_blue", out_blue_o, want.blue);
          if (out_alpha_o !== want.alpha) report_mismatch("out_alpha", out_alpha_o, want.alpha);
          if (out_x_o !== want.x) report_mismatch("out_x", out_x_o, want.x);
          if (out_y_o !== want.y) report_mismatch("out_y", out_y_o, want.y);
          if (frame_done_o !== want.done) report_mismatch("frame_done", frame_done_o, want.done);
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 99) < 20) begin
          stall_left = ($urandom_range(0, 99) < 12) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
        end
      end
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (calm || k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(logic op, logic [31:0] px, bit typed, logic [31:0] typed_px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    {alpha_i, blue_i, green_i, red_i} <= px;
    req_typed <= typed;
    req_typed_px <= typed_px;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (blur_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(bbe_pkg::cfg_idx_e idx, logic [10:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned radius, width, height;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_PIXEL;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    alpha_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bbe_pkg::CFG_RADIUS;
    cfg_data_i = '0;
    req_typed = 1'b0;
    req_typed_px = '0;
    calm = 1'b0;
    errors = 0;
    cycles = 0;
    frame_busy = 1'b0;
    items_sent = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_req(plan[i].op, plan[i].px, plan[i].typed, plan[i].typed_px);
      end
    end

    for (int frame = 0; items_sent < ITEM_TARGET; frame++) begin
      wait_idle();
      calm = 1'b0;
      if ($urandom_range(0, 3) == 0) send_req(OP_DRAIN, $urandom, 1'b0, '0);
      if (frame == 3) begin
        radius = 0;
        width = 11'h7FF;
        height = 0;
      end else if (frame == 6) begin
        radius = 31;
        width = 0;
        height = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        radius = $urandom_range(4, 31);
        width = $urandom_range(0, 2);
        height = $urandom_range(0, 2);
      end else begin
        radius = $urandom_range(0, 3);
        width = $urandom_range(0, 12);
        height = $urandom_range(0, 6);
      end
      wait_idle();
      write_reg(bbe_pkg::CFG_RADIUS, 11'(radius));
      write_reg(bbe_pkg::CFG_WIDTH, 11'(width));
      write_reg(bbe_pkg::CFG_HEIGHT, 11'(height));
      calm = ($urandom_range(0, 4) == 0);
      do begin
        if (frame_busy && $urandom_range(0, 99) < 4) begin
          send_req(OP_DRAIN, $urandom, 1'b0, '0);
        end else begin
          send_req(OP_PIXEL, $urandom, 1'b0, '0);
        end
      end while (frame_busy && wr_y < frm_h);
      if (frame == 1) wait_idle();
      while (frame_busy) begin
        send_req(logic'($urandom_range(0, 1)), $urandom, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (blur_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && blur_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
